/* design/tfuq_pkg.sv */
// shared types and constants for the tilt fall and upright qualifier
// no dependencies; imported by tilt_fall_and_upright_qualifier_core
package tfuq_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;

  localparam int LIMIT_W = 15;
  localparam int HOLD_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] FALL_LIMIT_RST    = 15'd3215;
  localparam logic [HOLD_W-1:0]  FALL_HOLD_RST     = 32'd500000;
  localparam logic [LIMIT_W-1:0] UPRIGHT_LIMIT_RST = 15'd356;
  localparam logic [HOLD_W-1:0]  UPRIGHT_HOLD_RST  = 32'd2000000;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_MODE   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_LIMIT    = 2'd0,
    REG_FALL_HOLD     = 2'd1,
    REG_UPRIGHT_LIMIT = 2'd2,
    REG_UPRIGHT_HOLD  = 2'd3
  } cfg_reg_t;

endpackage

/* design/tilt_fall_and_upright_qualifier_core.sv */
// tilt fall and upright qualifier, top level and only module
// depends on tfuq_pkg for reset values, opcodes and register indexes

// One transaction in, one transaction out, one per clock when the output side keeps up.
// An accepted item sits in an input register; the abs, the two band
// compares and the two elapsed-time subtract-and-compares run between that register
// and the result register, so out_tvalid comes from the result register, and an
// output stall can hold the item in the input register before out_tvalid rises.
// The input register refills in the same cycle it drains; an empty one takes a new item
// while a finished result still waits in the result register. Config writes are taken
// on any cycle with cfg_wr_en high and must only happen while the block is idle.
module tilt_fall_and_upright_qualifier_core
  import tfuq_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int IN_W  = ANGLE_BITS + TIME_BITS + 2,
  localparam int IN_TW = ((IN_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pitch, now_us, fall_enable, balance_enable (zero pad above)
  input  logic [IN_TW-1:0]      in_tdata,
  // opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fall_detected, balance_ready (zero pad above)
  output logic [7:0]            out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAG_W = ANGLE_BITS - 1;
  localparam int CMP_W = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;

  // config registers
  logic [LIMIT_W-1:0] fall_limit_r, upright_limit_r;
  logic [HOLD_W-1:0]  fall_hold_r, upright_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_limit_r    <= FALL_LIMIT_RST;
      fall_hold_r     <= FALL_HOLD_RST;
      upright_limit_r <= UPRIGHT_LIMIT_RST;
      upright_hold_r  <= UPRIGHT_HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FALL_LIMIT:    fall_limit_r    <= cfg_data[LIMIT_W-1:0];
        REG_FALL_HOLD:     fall_hold_r     <= cfg_data[HOLD_W-1:0];
        REG_UPRIGHT_LIMIT: upright_limit_r <= cfg_data[LIMIT_W-1:0];
        REG_UPRIGHT_HOLD:  upright_hold_r  <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  s1_valid_r;
  opcode_t               s1_op_r;
  logic [ANGLE_BITS-1:0] s1_pitch_r;
  logic [TIME_BITS-1:0]  s1_now_r;
  logic                  s1_fall_en_r, s1_bal_en_r;

  // result register
  logic       out_valid_r;
  logic [1:0] out_res_r;

  logic s1_adv, s1_fire, in_fire;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= opcode_t'(in_tuser);
      s1_pitch_r   <= in_tdata[ANGLE_BITS-1:0];
      s1_now_r     <= in_tdata[ANGLE_BITS +: TIME_BITS];
      s1_fall_en_r <= in_tdata[ANGLE_BITS + TIME_BITS];
      s1_bal_en_r  <= in_tdata[ANGLE_BITS + TIME_BITS + 1];
    end
  end

  // detector state
  logic                 fall_active_r, fall_active_nxt;
  logic                 fall_armed_r, fall_armed_nxt;
  logic                 fall_reported_r, fall_reported_nxt;
  logic [TIME_BITS-1:0] fall_start_r, fall_start_nxt;
  logic                 bal_active_r, bal_active_nxt;
  logic                 up_armed_r, up_armed_nxt;
  logic [TIME_BITS-1:0] up_start_r, up_start_nxt;
  logic                 fall_det_nxt, bal_ready_nxt;

  // saturating magnitude of pitch, band compares and elapsed-time checks
  logic [ANGLE_BITS-1:0] pitch_neg;
  logic [MAG_W-1:0]      mag;
  logic [TIME_BITS-1:0]  fall_elapsed, up_elapsed;
  logic                  above_fall, below_up, fall_hold_done, up_hold_done;

  always_comb begin
    pitch_neg = ~s1_pitch_r + {{(ANGLE_BITS-1){1'b0}}, 1'b1};
    if (!s1_pitch_r[ANGLE_BITS-1]) begin
      mag = s1_pitch_r[MAG_W-1:0];
    end else if (s1_pitch_r[MAG_W-1:0] == '0) begin
      // most negative code saturates to the top magnitude
      mag = '1;
    end else begin
      mag = pitch_neg[MAG_W-1:0];
    end
    above_fall     = CMP_W'(mag) > CMP_W'(fall_limit_r);
    below_up       = CMP_W'(mag) < CMP_W'(upright_limit_r);
    fall_elapsed   = s1_now_r - fall_start_r;
    up_elapsed     = s1_now_r - up_start_r;
    fall_hold_done = fall_elapsed >= TIME_BITS'(fall_hold_r);
    up_hold_done   = up_elapsed >= TIME_BITS'(upright_hold_r);
  end

  always_comb begin
    fall_active_nxt   = fall_active_r;
    fall_armed_nxt    = fall_armed_r;
    fall_reported_nxt = fall_reported_r;
    fall_start_nxt    = fall_start_r;
    bal_active_nxt    = bal_active_r;
    up_armed_nxt      = up_armed_r;
    up_start_nxt      = up_start_r;
    fall_det_nxt      = 1'b0;
    bal_ready_nxt     = 1'b0;
    case (s1_op_r)
      OP_MODE: begin
        fall_active_nxt = s1_fall_en_r;
        bal_active_nxt  = s1_bal_en_r;
        if (!s1_fall_en_r) begin
          fall_armed_nxt    = 1'b0;
          fall_reported_nxt = 1'b0;
          fall_start_nxt    = '0;
        end
        if (!s1_bal_en_r) begin
          up_armed_nxt = 1'b0;
          up_start_nxt = '0;
        end
      end
      default: begin
        if (fall_active_r) begin
          if (above_fall) begin
            if (!fall_armed_r) begin
              fall_armed_nxt    = 1'b1;
              fall_start_nxt    = s1_now_r;
              fall_reported_nxt = 1'b0;
            end else if (!fall_reported_r && fall_hold_done) begin
              fall_reported_nxt = 1'b1;
              fall_det_nxt      = 1'b1;
            end
          end else begin
            fall_armed_nxt    = 1'b0;
            fall_reported_nxt = 1'b0;
            fall_start_nxt    = '0;
          end
        end
        if (bal_active_r && below_up) begin
          if (!up_armed_r) begin
            up_armed_nxt = 1'b1;
            up_start_nxt = s1_now_r;
          end else if (up_hold_done) begin
            // window restarts on the next upright sample
            up_armed_nxt  = 1'b0;
            up_start_nxt  = '0;
            bal_ready_nxt = 1'b1;
          end
        end else begin
          up_armed_nxt = 1'b0;
          up_start_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_active_r   <= 1'b0;
      fall_armed_r    <= 1'b0;
      fall_reported_r <= 1'b0;
      fall_start_r    <= '0;
      bal_active_r    <= 1'b0;
      up_armed_r      <= 1'b0;
      up_start_r      <= '0;
    end else if (s1_fire) begin
      fall_active_r   <= fall_active_nxt;
      fall_armed_r    <= fall_armed_nxt;
      fall_reported_r <= fall_reported_nxt;
      fall_start_r    <= fall_start_nxt;
      bal_active_r    <= bal_active_nxt;
      up_armed_r      <= up_armed_nxt;
      up_start_r      <= up_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= {bal_ready_nxt, fall_det_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r};

`ifndef NO_ASSERTIONS
  a_reported_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    fall_reported_r |-> (fall_armed_r && fall_active_r))
    else $error("fall reported without an armed, enabled detector");

  a_upright_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    up_armed_r |-> bal_active_r)
    else $error("upright timer armed while readiness is disabled");

  a_fall_once: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && fall_det_nxt) |=> (fall_reported_r && out_valid_r && out_res_r[0]))
    else $error("fall result not recorded as reported");

  a_mode_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == OP_MODE) |=> (out_valid_r && out_res_r == 2'b00))
    else $error("mode change transaction produced a nonzero result");
`endif

endmodule

/* tb/sv/tilt_fall_and_upright_qualifier_core_tb.sv */
// self-checking testbench for tilt_fall_and_upright_qualifier_core: directed and random items,
// each result checked against an in-bench qualifier with mirrored registers and state
// depends on tfuq_pkg and the core rtl only
module tilt_fall_and_upright_qualifier_core_tb;
  import tfuq_pkg::*;

  localparam int IN_TW      = 72;
  localparam int STALL_MAX  = 5000;
  localparam int SHOW_MAX   = 10;

  typedef struct packed {
    logic fall_detected;
    logic balance_ready;
  } tilt_flags_t;

  typedef enum int {
    BAND_FALL,
    BAND_UPRIGHT
  } band_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TW-1:0]      in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tilt_fall_and_upright_qualifier_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // mirrored registers
  logic [LIMIT_W-1:0] fall_limit_q   = FALL_LIMIT_RST;
  logic [HOLD_W-1:0]  fall_hold_q    = FALL_HOLD_RST;
  logic [LIMIT_W-1:0] upright_limit_q = UPRIGHT_LIMIT_RST;
  logic [HOLD_W-1:0]  upright_hold_q = UPRIGHT_HOLD_RST;

  // mirrored qualifier state
  logic        fall_on_q = 1'b0;
  logic        balance_on_q = 1'b0;
  logic        fall_armed_q = 1'b0;
  logic        fall_seen_q = 1'b0;
  logic [47:0] fall_since_q = '0;
  logic        upright_armed_q = 1'b0;
  logic [47:0] upright_since_q = '0;

  tilt_flags_t pending_flags[$];
  tilt_flags_t got_flags;
  tilt_flags_t want_flags;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  logic        idle_on = 1'b1;
  logic [47:0] stamp_us = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic qualify_item(opcode_t op, logic [15:0] pitch, logic [47:0] now_us,
                              logic fall_en, logic bal_en);
    logic [15:0] mag;
    logic [47:0] elapsed;
    tilt_flags_t flags;
    flags = '0;
    if (op == OP_MODE) begin
      fall_on_q = fall_en;
      balance_on_q = bal_en;
      if (!fall_en) begin
        fall_armed_q = 1'b0;
        fall_since_q = '0;
        fall_seen_q = 1'b0;
      end
      if (!bal_en) begin
        upright_armed_q = 1'b0;
        upright_since_q = '0;
      end
    end else begin
      // saturating magnitude: the most negative pitch maps to the largest positive
      if (pitch[15]) begin
        mag = -pitch;
        if (mag == 16'h8000) mag = 16'h7FFF;
      end else begin
        mag = pitch;
      end
      if (fall_on_q) begin
        if (mag > {1'b0, fall_limit_q}) begin
          if (!fall_armed_q) begin
            fall_armed_q = 1'b1;
            fall_since_q = now_us;
            fall_seen_q = 1'b0;
          end else begin
            elapsed = now_us - fall_since_q;
            if (!fall_seen_q && elapsed >= {16'b0, fall_hold_q}) begin
              fall_seen_q = 1'b1;
              flags.fall_detected = 1'b1;
            end
          end
        end else begin
          fall_armed_q = 1'b0;
          fall_since_q = '0;
          fall_seen_q = 1'b0;
        end
      end
      if (balance_on_q && mag < {1'b0, upright_limit_q}) begin
        if (!upright_armed_q) begin
          upright_armed_q = 1'b1;
          upright_since_q = now_us;
        end else begin
          elapsed = now_us - upright_since_q;
          if (elapsed >= {16'b0, upright_hold_q}) begin
            upright_armed_q = 1'b0;
            upright_since_q = '0;
            flags.balance_ready = 1'b1;
          end
        end
      end else begin
        upright_armed_q = 1'b0;
        upright_since_q = '0;
      end
    end
    pending_flags.push_back(flags);
  endtask

  // valid stays high after acceptance so back-to-back items need no second assignment;
  // anything that lets time pass without a new item must lower it first
  task automatic send_item(opcode_t op, logic [15:0] pitch, logic [47:0] now_us,
                           logic fall_en, logic bal_en);
    while (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, bal_en, fall_en, now_us, pitch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    qualify_item(op, pitch, now_us, fall_en, bal_en);
  endtask

  task automatic send_sample(logic [15:0] pitch, logic [47:0] now_us);
    send_item(OP_SAMPLE, pitch, now_us, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // unused sample fields still get random bits
  task automatic send_mode(logic fall_en, logic bal_en);
    send_item(OP_MODE, 16'($urandom), {16'($urandom), 32'($urandom)}, fall_en, bal_en);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(logic [LIMIT_W-1:0] fall_lim, logic [HOLD_W-1:0] fall_hold,
                              logic [LIMIT_W-1:0] up_lim, logic [HOLD_W-1:0] up_hold);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FALL_LIMIT;
    cfg_data  <= {17'b0, fall_lim};
    @(posedge clk);
    cfg_index <= REG_FALL_HOLD;
    cfg_data  <= fall_hold;
    @(posedge clk);
    cfg_index <= REG_UPRIGHT_LIMIT;
    cfg_data  <= {17'b0, up_lim};
    @(posedge clk);
    cfg_index <= REG_UPRIGHT_HOLD;
    cfg_data  <= up_hold;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fall_limit_q = fall_lim;
    fall_hold_q = fall_hold;
    upright_limit_q = up_lim;
    upright_hold_q = up_hold;
  endtask

  // pitch inside the chosen band, sometimes right at its edge; random if the band is empty
  function automatic logic [15:0] band_pitch(band_t band);
    int lo;
    int hi;
    int m;
    if (band == BAND_FALL) begin
      lo = int'(fall_limit_q) + 1;
      hi = 32768;
    end else begin
      lo = 0;
      hi = int'(upright_limit_q) - 1;
    end
    if (lo > hi) return 16'($urandom);
    m = $urandom_range(hi, lo);
    if ($urandom_range(9) == 0) m = (band == BAND_FALL) ? lo : hi;
    if (m == 32768) return 16'h8000;
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  task automatic advance_time(logic [31:0] step_max);
    int r;
    r = $urandom_range(99);
    if (r < 2) stamp_us = stamp_us - 48'($urandom_range(1000, 1));
    else if (r < 3) stamp_us = stamp_us + {16'($urandom), 32'($urandom)};
    else stamp_us = stamp_us + 48'($urandom_range(step_max, 0));
  endtask

  // mostly in-band runs with random timing, broken by noise samples and mode changes
  task automatic run_episodes(int count, logic [31:0] step_max);
    int sent;
    int kind;
    int len;
    band_t band;
    sent = 0;
    stamp_us = {16'($urandom), 32'($urandom)};
    send_mode(1'b1, 1'b1);
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        if ($urandom_range(9) < 7) send_mode(1'b1, 1'b1);
        else send_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (kind < 12) begin
        advance_time(step_max);
        send_sample(16'($urandom), stamp_us);
        sent++;
      end else begin
        band = $urandom_range(1) ? BAND_FALL : BAND_UPRIGHT;
        len = $urandom_range(10, 1);
        repeat (len) begin
          advance_time(step_max);
          send_sample(band_pitch(band), stamp_us);
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    logic [47:0] t0;
    t0 = 48'h1234_5678_9ABC;
    send_sample(16'h0100, t0);                  // both detectors still disabled
    send_mode(1'b1, 1'b1);
    send_sample(16'h8000, t0);                  // saturated magnitude arms the fall timer
    send_sample(16'h7FFF, t0 + 48'd499999);     // one microsecond short
    send_sample(16'h7FFF, t0 + 48'd500000);     // fall confirmed
    send_sample(16'h8001, t0 + 48'd900000);     // only once per episode
    send_sample(16'd3215, t0 + 48'd1000000);    // equal to limit leaves the band
    send_sample(16'd3216, t0 + 48'd1100000);    // just above rearms
    send_sample(16'h0000, t0 + 48'd2000000);    // arms upright
    send_sample(16'd355, t0 + 48'd3999999);
    send_sample(16'hFE9D, t0 + 48'd4000000);    // readiness, window restarts
    send_sample(16'd356, t0 + 48'd4100000);     // equal to upright limit clears
    send_sample(16'h0000, t0 + 48'd4200000);
    send_sample(16'h0000, t0 + 48'd4100000);    // time going backwards looks huge
    send_sample(16'd4000, 48'hFFFF_FFFE_7960);  // arm just before wraparound
    send_sample(16'hF060, 48'd400000);          // elapsed across wrap is exactly the hold
    send_mode(1'b0, 1'b1);                      // disabling fall clears its state
    send_sample(16'h7FFF, 48'd500000);
    send_sample(16'h0000, 48'd600000);
    send_mode(1'b1, 1'b0);
    send_sample(16'h0000, 48'hFFFF_FFFF_FFFF);
    send_sample(16'h0000, 48'h8000_0000_0000);
    send_mode(1'b0, 1'b0);
    send_sample(16'h8000, 48'h0000_0000_0001);
  endtask

  task automatic test_limit_extremes();
    program_regs(15'd0, 32'd0, 15'h7FFF, 32'd0);
    run_episodes(120, 32'd1000);
    program_regs(15'h7FFF, 32'hFFFF_FFFF, 15'd0, 32'hFFFF_FFFF);
    run_episodes(120, 32'hFFFF_FFFF);
    program_regs(15'd0, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF);
    run_episodes(120, 32'hFFFF_FFFF);
    program_regs(15'h7FFF, 32'd0, 15'd0, 32'd0);
    run_episodes(120, 32'd1000);
  endtask

  task automatic test_default_settings();
    program_regs(FALL_LIMIT_RST, FALL_HOLD_RST, UPRIGHT_LIMIT_RST, UPRIGHT_HOLD_RST);
    run_episodes(200, 32'd300000);
  endtask

  task automatic test_short_holds();
    repeat (2) begin
      program_regs(15'($urandom_range(20000)), 32'($urandom_range(2000)),
                   15'($urandom_range(20000)), 32'($urandom_range(2000)));
      run_episodes(300, 32'd600);
    end
    // long stretch with both sides at full rate
    idle_on = 1'b0;
    run_episodes(200, 32'd600);
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pauses();
    program_regs(15'($urandom_range(32767)), 32'($urandom_range(5000)),
                 15'($urandom_range(32767)), 32'($urandom_range(5000)));
    repeat (5) begin
      run_episodes(40, 32'd1500);
      wait_drain();
    end
  endtask

  always @(posedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
    if (rst_n && out_tvalid && out_tready) begin
      got_flags.fall_detected = out_tdata[0];
      got_flags.balance_ready = out_tdata[1];
      if (pending_flags.size() == 0) begin
        if (mismatch_count < SHOW_MAX)
          $display("unexpected result: fall=%b ready=%b", got_flags.fall_detected,
                   got_flags.balance_ready);
        mismatch_count++;
      end else begin
        want_flags = pending_flags.pop_front();
        if (got_flags !== want_flags) begin
          if (mismatch_count < SHOW_MAX)
            $display("mismatch: expected fall=%b ready=%b, got fall=%b ready=%b",
                     want_flags.fall_detected, want_flags.balance_ready,
                     got_flags.fall_detected, got_flags.balance_ready);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: no transaction on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_extremes();
    test_default_settings();
    test_short_holds();
    test_drain_pauses();
    wait_drain();
    repeat (10) @(posedge clk);
    if (pending_flags.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* tilt_fall_and_upright_qualifier_core.f */
design/tfuq_pkg.sv
design/tilt_fall_and_upright_qualifier_core.sv
tb/sv/tilt_fall_and_upright_qualifier_core_tb.sv
